@@ sv/kpl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kpl_pkg;

  // Default number of PIN positions.
  localparam int unsigned KPL_PIN_DIGITS_DEF = 8;

  // Reset value of the trial limit register.
  localparam logic [3:0] KPL_MAX_TRIALS_RST = 4'd3;

  // Key that closes a setting or entry sequence early.
  localparam logic [3:0] KPL_KEY_END = 4'hE;
  // Menu keys.
  localparam logic [3:0] KPL_KEY_SET   = 4'h0;
  localparam logic [3:0] KPL_KEY_ENTER = 4'h1;

  // Register index of max_trials.
  localparam logic KPL_REG_MAX_TRIALS = 1'b0;

  // Character echoed for each digit during entry.
  localparam logic [6:0] KPL_CHAR_STAR = 7'h2A;

  typedef enum logic [1:0] {
    MODE_MENU   = 2'd0,
    MODE_SET    = 2'd1,
    MODE_ENTER  = 2'd2,
    MODE_LOCKED = 2'd3
  } kpl_mode_t;

  typedef enum logic [3:0] {
    ST_IGNORED        = 4'd0,
    ST_SET_STARTED    = 4'd1,
    ST_ENTRY_STARTED  = 4'd2,
    ST_DIGIT_TAKEN    = 4'd3,
    ST_PIN_SET        = 4'd4,
    ST_VALID          = 4'd5,
    ST_INVALID        = 4'd6,
    ST_LOCKED_OUT     = 4'd7,
    ST_IGNORED_LOCKED = 4'd8
  } kpl_status_t;

  // Write request from the sequencer to the PIN bank.
  typedef struct packed {
    logic       set_we;
    logic       ent_we;
    logic [3:0] idx;
    logic [3:0] value;
  } kpl_pin_wr_t;

  // Digit value stored for each key.
  function automatic logic [3:0] kpl_digit_value(input logic [3:0] key);
    logic [3:0] v;
    case (key)
      4'h0:    v = 4'd1;
      4'h1:    v = 4'd2;
      4'h2:    v = 4'd3;
      4'h3:    v = 4'd10;
      4'h4:    v = 4'd4;
      4'h5:    v = 4'd5;
      4'h6:    v = 4'd6;
      4'h7:    v = 4'd11;
      4'h8:    v = 4'd7;
      4'h9:    v = 4'd8;
      4'hA:    v = 4'd9;
      4'hB:    v = 4'd12;
      4'hC:    v = 4'd14;
      4'hF:    v = 4'd13;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

  // ASCII character printed on the keycap.
  function automatic logic [6:0] kpl_key_char(input logic [3:0] key);
    logic [6:0] c;
    case (key)
      4'h0:    c = 7'h31;
      4'h1:    c = 7'h32;
      4'h2:    c = 7'h33;
      4'h3:    c = 7'h41;
      4'h4:    c = 7'h34;
      4'h5:    c = 7'h35;
      4'h6:    c = 7'h36;
      4'h7:    c = 7'h42;
      4'h8:    c = 7'h37;
      4'h9:    c = 7'h38;
      4'hA:    c = 7'h39;
      4'hB:    c = 7'h43;
      4'hC:    c = 7'h2A;
      4'hD:    c = 7'h30;
      4'hF:    c = 7'h44;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // Keys that carry a decimal digit.
  function automatic logic kpl_key_numeric(input logic [3:0] key);
    logic n;
    case (key) inside
      4'h0, 4'h1, 4'h2, 4'h4, 4'h5, 4'h6, 4'h8, 4'h9, 4'hA, 4'hD: n = 1'b1;
      default: n = 1'b0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

@@ sv/kpl_pin_bank.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kpl_pin_bank
  import kpl_pkg::*;
#(
  parameter int unsigned PIN_DIGITS = KPL_PIN_DIGITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire kpl_pin_wr_t pin_wr,
  output logic             match
);

  logic [3:0] stored_r  [PIN_DIGITS];
  logic [3:0] entered_r [PIN_DIGITS];
  logic [3:0] entered_view [PIN_DIGITS];

  // Both PINs are cleared by reset; one position is written per beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIN_DIGITS; i++) begin
        stored_r[i]  <= 4'd0;
        entered_r[i] <= 4'd0;
      end
    end else begin
      for (int i = 0; i < PIN_DIGITS; i++) begin
        if (pin_wr.set_we && pin_wr.idx == 4'(i)) begin
          stored_r[i] <= pin_wr.value;
        end
        if (pin_wr.ent_we && pin_wr.idx == 4'(i)) begin
          entered_r[i] <= pin_wr.value;
        end
      end
    end
  end

  // The compare sees the digit being written this beat, so the last digit counts.
  always_comb begin
    for (int i = 0; i < PIN_DIGITS; i++) begin
      entered_view[i] = (pin_wr.ent_we && pin_wr.idx == 4'(i)) ? pin_wr.value : entered_r[i];
    end
  end

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < PIN_DIGITS; i++) begin
      if (entered_view[i] != stored_r[i]) begin
        match = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/keypad_pin_lock.sv @@
// Keypad PIN lock. One key code is taken per beat and one result beat comes
// out for it in the next cycle, from an output register; a new key is taken in
// every cycle as long as the result register is empty or being drained, so the
// block sustains one key per clock. In the menu, key 0 starts setting the PIN
// and key 1 starts entry; key E or the last position closes either sequence.
// A failed entry costs one trial and restarts entry, and the block locks until
// reset when no trials remain. Writing max_trials (cfg_paddr[2] low) also
// reloads the trial counter; write it only while no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module keypad_pin_lock
  import kpl_pkg::*;
#(
  parameter int unsigned PIN_DIGITS = KPL_PIN_DIGITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Key channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_key_code,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_echo_valid,
  output logic [6:0]       out_echo_char,
  output logic [3:0]       out_status,
  output logic [3:0]       out_trials_left,
  // Configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  kpl_mode_t   mode_r, mode_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [3:0]  trials_r, trials_nxt;
  logic [3:0]  max_trials_r;
  logic [4:0]  idx_inc;
  logic        seq_done;
  logic        fire;
  logic        cfg_wr;
  logic        pin_match;
  kpl_pin_wr_t pin_wr;
  logic        echo_v;
  logic [6:0]  echo_c;
  kpl_status_t status;

  logic        out_valid_r;
  logic        echo_valid_r;
  logic [6:0]  echo_char_r;
  logic [3:0]  status_r;
  logic [3:0]  trials_left_r;

  // Handshakes.
  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                    && (cfg_paddr[2] == KPL_REG_MAX_TRIALS);

  // Configuration readback.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == KPL_REG_MAX_TRIALS) ? {28'd0, max_trials_r} : 32'd0;

  // Position bookkeeping.
  assign idx_inc  = {1'b0, idx_r} + 5'd1;
  assign seq_done = (idx_inc >= 5'(PIN_DIGITS)) || (idx_inc[3:0] == 4'd0);

  kpl_pin_bank #(
    .PIN_DIGITS(PIN_DIGITS)
  ) u_pin_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .pin_wr(pin_wr),
    .match (pin_match)
  );

  // Mode, position and trial registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_MENU;
      idx_r        <= 4'd0;
      trials_r     <= KPL_MAX_TRIALS_RST;
      max_trials_r <= KPL_MAX_TRIALS_RST;
    end else begin
      mode_r <= mode_nxt;
      idx_r  <= idx_nxt;
      if (cfg_wr) begin
        max_trials_r <= cfg_pwdata[3:0];
        trials_r     <= cfg_pwdata[3:0];
      end else begin
        trials_r <= trials_nxt;
      end
    end
  end

  // PIN write for the key on the input; a digit is stored only on a taken beat.
  always_comb begin
    pin_wr        = '0;
    pin_wr.idx    = idx_r;
    pin_wr.value  = kpl_digit_value(in_key_code);
    pin_wr.set_we = fire && (mode_r == MODE_SET) && (in_key_code != KPL_KEY_END);
    pin_wr.ent_we = fire && (mode_r == MODE_ENTER) && kpl_key_numeric(in_key_code);
  end

  // Next state and result for the key on the input.
  always_comb begin
    mode_nxt   = mode_r;
    idx_nxt    = idx_r;
    trials_nxt = trials_r;
    echo_v     = 1'b0;
    echo_c     = 7'd0;
    status     = ST_IGNORED;

    unique case (mode_r)
      MODE_MENU: begin
        if (in_key_code == KPL_KEY_SET) begin
          mode_nxt = MODE_SET;
          idx_nxt  = 4'd0;
          status   = ST_SET_STARTED;
        end else if (in_key_code == KPL_KEY_ENTER) begin
          mode_nxt = MODE_ENTER;
          idx_nxt  = 4'd0;
          status   = ST_ENTRY_STARTED;
        end
      end
      MODE_SET: begin
        if (in_key_code == KPL_KEY_END) begin
          mode_nxt = MODE_MENU;
          status   = ST_PIN_SET;
        end else begin
          idx_nxt       = idx_inc[3:0];
          echo_v        = 1'b1;
          echo_c        = kpl_key_char(in_key_code);
          status        = ST_DIGIT_TAKEN;
          if (seq_done) begin
            mode_nxt = MODE_MENU;
            status   = ST_PIN_SET;
          end
        end
      end
      MODE_ENTER: begin
        if (in_key_code != KPL_KEY_END && kpl_key_numeric(in_key_code)) begin
          idx_nxt       = idx_inc[3:0];
          echo_v        = 1'b1;
          echo_c        = KPL_CHAR_STAR;
          status        = ST_DIGIT_TAKEN;
        end
        // Closing compare on key E or on the last position.
        if (in_key_code == KPL_KEY_END || (kpl_key_numeric(in_key_code) && seq_done)) begin
          if (pin_match) begin
            mode_nxt = MODE_MENU;
            status   = ST_VALID;
          end else begin
            idx_nxt = 4'd0;
            if (trials_r <= 4'd1) begin
              trials_nxt = 4'd0;
              mode_nxt   = MODE_LOCKED;
              status     = ST_LOCKED_OUT;
            end else begin
              trials_nxt = trials_r - 4'd1;
              mode_nxt   = MODE_ENTER;
              status     = ST_INVALID;
            end
          end
        end
      end
      MODE_LOCKED: begin
        status = ST_IGNORED_LOCKED;
      end
    endcase

    // Nothing changes unless a key beat is taken.
    if (!fire) begin
      mode_nxt      = mode_r;
      idx_nxt       = idx_r;
      trials_nxt    = trials_r;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      echo_valid_r  <= echo_v;
      echo_char_r   <= echo_c;
      status_r      <= status;
      trials_left_r <= trials_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_echo_valid  = echo_valid_r;
  assign out_echo_char   = echo_char_r;
  assign out_status      = status_r;
  assign out_trials_left = trials_left_r;

endmodule

`default_nettype wire

@@ sv/kpl_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kpl_checker
  import kpl_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_echo_valid,
  input wire logic [6:0] out_echo_char,
  input wire logic [3:0] out_status,
  input wire logic [3:0] out_trials_left
);

  // Every accepted key produces a result beat in the next cycle.
  a_key_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted key produced no result beat");

  // A stalled result beat holds its payload.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_echo_char) && $stable(out_trials_left))
    else $error("stalled result beat changed");

  // An echo only comes with a taken digit or a closing status.
  a_echo_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_echo_valid |-> out_status == ST_DIGIT_TAKEN
      || out_status == ST_PIN_SET || out_status == ST_VALID
      || out_status == ST_INVALID || out_status == ST_LOCKED_OUT)
    else $error("echo with a status that takes no digit");

  // The failed attempt that locks the block leaves no trials. A later register
  // write may reload the counter while the block stays locked.
  a_lock_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_LOCKED_OUT |-> out_trials_left == 4'd0)
    else $error("locked with trials remaining");

endmodule

bind keypad_pin_lock kpl_checker u_kpl_checker (.*);

`default_nettype wire
